### src/bso_pkg.sv
// shared constants, types and sine table for the band-limited square oscillator
package bso_pkg;

    localparam int SAMPLE_RATE     = 44100;
    localparam int MAX_HARMONIC    = 15;
    localparam int SINE_TABLE_BITS = 10;

    localparam int FREQ_W   = 15;
    localparam int SAMPLE_W = 16;
    localparam int USED_W   = 4;
    localparam int MAG_W    = 15;

    localparam int PHASE_W = $clog2(SAMPLE_RATE);
    localparam int ACC_W   = ((PHASE_W > FREQ_W) ? PHASE_W : FREQ_W) + 1;
    localparam int NUM_ODD = (MAX_HARMONIC + 1) / 2;
    localparam int H_W     = $clog2(NUM_ODD + 1);
    localparam int HI_W    = (NUM_ODD > 1) ? $clog2(NUM_ODD) : 1;
    localparam int K_W     = $clog2(2 * NUM_ODD + 2);
    localparam int SUM_W   = 32 + H_W;

    localparam int TABLE_SIZE = 1 << SINE_TABLE_BITS;
    localparam int QUARTER    = TABLE_SIZE >> 2;
    localparam int Q_W        = SINE_TABLE_BITS - 2;
    localparam int RECIP_W    = SINE_TABLE_BITS + 1;

    localparam logic [63:0] RECIP_FULL =
        (64'd1 << (PHASE_W + SINE_TABLE_BITS)) / SAMPLE_RATE;

    localparam logic [63:0] ONE_Q30    = 64'd1 << 30;
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    typedef logic [FREQ_W-1:0]          freq_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [USED_W-1:0]          used_t;
    typedef logic [MAG_W-1:0]           mag_t;
    typedef logic [QUARTER-1:0][MAG_W-1:0] qtab_t;

    // quarter-wave sine as q0.15 magnitude, odd series in q2.30
    function automatic mag_t quarter_sine(input logic [63:0] j);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] r;
        logic [63:0] s;
        x  = (j * TWO_PI_Q30 + 64'(TABLE_SIZE >> 1)) >> SINE_TABLE_BITS;
        x2 = (x * x) >> 30;
        r  = ONE_Q30;
        r  = ONE_Q30 - ((x2 * r) >> 30) / 64'd156;
        r  = ONE_Q30 - ((x2 * r) >> 30) / 64'd110;
        r  = ONE_Q30 - ((x2 * r) >> 30) / 64'd72;
        r  = ONE_Q30 - ((x2 * r) >> 30) / 64'd42;
        r  = ONE_Q30 - ((x2 * r) >> 30) / 64'd20;
        r  = ONE_Q30 - ((x2 * r) >> 30) / 64'd6;
        s  = (x * r) >> 30;
        s  = (s + 64'd16384) >> 15;
        if (s > 64'd32767)
        begin
            s = 64'd32767;
        end
        return s[MAG_W-1:0];
    endfunction

    function automatic qtab_t build_qtab();
        qtab_t t;
        for (int i = 0; i < QUARTER; i++)
        begin
            t[i] = quarter_sine(64'(i));
        end
        return t;
    endfunction

    localparam qtab_t QTAB = build_qtab();
    localparam mag_t  QTOP = quarter_sine(64'(QUARTER));

endpackage

### src/bso_if.sv
// handshake channels for the tone requests and the audio samples
interface bso_tone_if;
    import bso_pkg::*;
    logic  valid;
    logic  ready;
    freq_t pitch_hz;
    logic  start_note;
    modport source (output valid, output pitch_hz, output start_note, input ready);
    modport sink   (input valid, input pitch_hz, input start_note, output ready);
endinterface

interface bso_audio_if;
    import bso_pkg::*;
    logic    valid;
    logic    ready;
    sample_t sample;
    used_t   harmonics_used;
    modport source (output valid, output sample, output harmonics_used, input ready);
    modport sink   (input valid, input sample, input harmonics_used, output ready);
endinterface

### src/bandlimited_square_oscillator.sv
// band-limited square oscillator: sum of odd sine harmonics over a shared sequencer
//
// tone channel: one item per audio sample, with pitch_hz and start_note;
// start_note set makes this sample use phase zero and restarts the tone there.
// audio channel: one item per tone item, the signed q2.14 sample and the count
// of odd harmonics that stayed at or below half the sample rate.
// one item is worked at a time; tone.ready is high only while the block waits.
// after acceptance the phase step is wrapped by a subtraction when it reaches
// the sample rate; then each summed harmonic passes the index multiply, its
// correction, the quarter-wave table read, the 1/k reciprocal multiply and
// the accumulate, before the sample is loaded into the output register.
// the next tone item is taken as soon as the sample sits in the output
// register, even while the receiver stalls; a new sample waits for that
// register to empty. reset clears the phase to zero and drops audio.valid.
module bandlimited_square_oscillator (
    input  logic         clk,
    input  logic         rst_n,
    bso_tone_if.sink     tone,
    bso_audio_if.source  audio
);
    import bso_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_WRAP   = 3'd1;
    localparam logic [2:0] ST_CHECK  = 3'd2;
    localparam logic [2:0] ST_INDEX  = 3'd3;
    localparam logic [2:0] ST_READ   = 3'd4;
    localparam logic [2:0] ST_DIV    = 3'd5;
    localparam logic [2:0] ST_ACCUM  = 3'd6;
    localparam logic [2:0] ST_FINISH = 3'd7;

    localparam int KF_W = K_W + FREQ_W;
    localparam int IP_W = PHASE_W + RECIP_W;
    localparam int IR_W = PHASE_W + SINE_TABLE_BITS;
    localparam int DP_W = MAG_W + 32;
    localparam int QE_W = MAG_W + 16;
    localparam int KQ_W = QE_W + K_W;
    localparam int V_W  = SUM_W + 1;
    localparam int SH_W = V_W - 17;

    localparam logic [PHASE_W:0]   SR_P   = (PHASE_W + 1)'(SAMPLE_RATE);
    localparam logic [ACC_W-1:0]   SR_A   = ACC_W'(SAMPLE_RATE);
    localparam logic [KF_W-1:0]    HALF_K = KF_W'(SAMPLE_RATE / 2);
    localparam logic [IR_W-1:0]    SR_R   = IR_W'(SAMPLE_RATE);
    localparam logic [RECIP_W-1:0] RECIP  = RECIP_FULL[RECIP_W-1:0];
    localparam logic [H_W-1:0]     H_END  = H_W'(NUM_ODD);

    logic [2:0]          state_reg;
    logic [ACC_W-1:0]    acc_reg;
    freq_t               freq_reg;
    logic [PHASE_W-1:0]  ph2_reg;
    logic [PHASE_W-1:0]  p_reg;
    logic [H_W-1:0]      h_reg;
    logic [SINE_TABLE_BITS-1:0] est_reg;
    logic [SINE_TABLE_BITS-1:0] idx_reg;
    mag_t                mag_reg;
    logic                neg_reg;
    logic [QE_W-1:0]     qest_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic                out_valid_reg;
    sample_t             sample_reg;
    used_t               used_reg;

    logic [31:0] rk [NUM_ODD];

    for (genvar g = 0; g < NUM_ODD; g++)
    begin : g_rk
        localparam logic [63:0] RK_FULL = 64'hFFFF_FFFF / (2 * g + 1);
        assign rk[g] = RK_FULL[31:0];
    end

    logic [PHASE_W-1:0] phase_sel;
    logic [PHASE_W:0]   ph2_sum;
    logic [PHASE_W-1:0] ph2_next;
    logic [K_W-1:0]     k_val;
    logic [KF_W-1:0]    kf;
    logic [IP_W-1:0]    idx_prod;
    logic [IR_W-1:0]    idx_rem;
    logic [1:0]         quad;
    logic [Q_W-1:0]     qoff;
    logic [Q_W-1:0]     qsel;
    mag_t               sine_mag;
    logic [DP_W-1:0]    div_prod;
    logic [KQ_W-1:0]    kq;
    logic [QE_W-1:0]    div_rem;
    logic [QE_W-1:0]    quot;
    logic signed [SUM_W-1:0] term;
    logic [PHASE_W:0]   p_sum;
    logic [PHASE_W-1:0] p_next;
    logic signed [V_W-1:0]  v_round;
    logic signed [SH_W-1:0] v_shift;
    sample_t            sample_sat;
    logic [H_W+3:0]     h_ext;
    used_t              used_sat;
    logic               out_load;

    always_comb
    begin
        phase_sel = tone.start_note ? '0 : acc_reg[PHASE_W-1:0];
        ph2_sum   = {phase_sel, 1'b0};
        ph2_next  = (ph2_sum >= SR_P) ? PHASE_W'(ph2_sum - SR_P) : ph2_sum[PHASE_W-1:0];

        k_val    = {(K_W - 1)'(h_reg), 1'b1};
        kf       = KF_W'(k_val) * KF_W'(freq_reg);
        idx_prod = IP_W'(p_reg) * IP_W'(RECIP);

        idx_rem  = {p_reg, {SINE_TABLE_BITS{1'b0}}} - IR_W'(est_reg) * SR_R;

        quad = idx_reg[SINE_TABLE_BITS-1:SINE_TABLE_BITS-2];
        qoff = idx_reg[Q_W-1:0];
        qsel = quad[0] ? (Q_W'(0) - qoff) : qoff;
        if (quad[0] && (qoff == '0))
        begin
            sine_mag = QTOP;
        end
        else
        begin
            sine_mag = QTAB[qsel];
        end

        div_prod = DP_W'(mag_reg) * DP_W'(rk[h_reg[HI_W-1:0]]);

        kq      = KQ_W'(qest_reg) * KQ_W'(k_val);
        div_rem = {mag_reg, 16'd0} - kq[QE_W-1:0];
        quot    = qest_reg + QE_W'(div_rem >= QE_W'(k_val));
        term    = neg_reg ? -SUM_W'(quot) : SUM_W'(quot);

        p_sum  = (PHASE_W + 1)'(p_reg) + (PHASE_W + 1)'(ph2_reg);
        p_next = (p_sum >= SR_P) ? PHASE_W'(p_sum - SR_P) : p_sum[PHASE_W-1:0];

        v_round = V_W'(sum_reg) + V_W'(65536);
        v_shift = SH_W'(v_round >>> 17);
        if (v_shift > SH_W'(32767))
        begin
            sample_sat = 16'sd32767;
        end
        else if (v_shift < -SH_W'(32768))
        begin
            sample_sat = -16'sd32768;
        end
        else
        begin
            sample_sat = v_shift[SAMPLE_W-1:0];
        end

        h_ext    = (H_W + 4)'(h_reg);
        used_sat = (h_ext > (H_W + 4)'(15)) ? 4'hF : h_ext[3:0];

        out_load = (state_reg == ST_FINISH) && (!out_valid_reg || audio.ready);
    end

    assign tone.ready           = (state_reg == ST_IDLE);
    assign audio.valid          = out_valid_reg;
    assign audio.sample         = sample_reg;
    assign audio.harmonics_used = used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (audio.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (tone.valid)
                    begin
                        acc_reg   <= ACC_W'(phase_sel) + ACC_W'(tone.pitch_hz);
                        state_reg <= ST_WRAP;
                    end
                end
                ST_WRAP:
                begin
                    if (acc_reg >= SR_A)
                    begin
                        acc_reg <= acc_reg - SR_A;
                    end
                    else
                    begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    if ((h_reg == H_END) || (kf > HALF_K))
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        state_reg <= ST_INDEX;
                    end
                end
                ST_INDEX:
                begin
                    state_reg <= ST_READ;
                end
                ST_READ:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    state_reg <= ST_ACCUM;
                end
                ST_ACCUM:
                begin
                    state_reg <= ST_CHECK;
                end
                ST_FINISH:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (tone.valid)
                begin
                    freq_reg <= tone.pitch_hz;
                    p_reg    <= phase_sel;
                    ph2_reg  <= ph2_next;
                    h_reg    <= '0;
                    sum_reg  <= '0;
                end
            end
            ST_CHECK:
            begin
                est_reg <= idx_prod[PHASE_W +: SINE_TABLE_BITS];
            end
            ST_INDEX:
            begin
                idx_reg <= est_reg + SINE_TABLE_BITS'(idx_rem >= SR_R);
            end
            ST_READ:
            begin
                mag_reg <= sine_mag;
                neg_reg <= quad[1];
            end
            ST_DIV:
            begin
                qest_reg <= div_prod[16 +: QE_W];
            end
            ST_ACCUM:
            begin
                sum_reg <= sum_reg + term;
                p_reg   <= p_next;
                h_reg   <= h_reg + H_W'(1);
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    sample_reg <= sample_sat;
                    used_reg   <= used_sat;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

### src/bso_checker.sv
// port-level checks for the band-limited square oscillator, bound to the top level
module bso_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input bso_pkg::sample_t sample,
    input bso_pkg::used_t   harmonics_used
);
    import bso_pkg::*;

    localparam int USED_MAX = (NUM_ODD > 15) ? 15 : NUM_ODD;

    // a waiting sample holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample) && $stable(harmonics_used))
        else $error("audio item changed while stalled");

    // one item at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("tone item taken while busy");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> harmonics_used <= USED_MAX[USED_W-1:0])
        else $error("harmonic count beyond limit");

    // no harmonic summed gives silence
    a_silent_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (harmonics_used == '0) |-> sample == '0)
        else $error("nonzero sample with no harmonics");

endmodule

bind bandlimited_square_oscillator bso_checker u_bso_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (tone.valid),
    .in_ready       (tone.ready),
    .out_valid      (audio.valid),
    .out_ready      (audio.ready),
    .sample         (audio.sample),
    .harmonics_used (audio.harmonics_used)
);
